// File: hw/rtl/hnt_pkg.sv
// hnt_pkg: shared constants and types of the heard node table
// used by the result channel interface, the sequencer and the top level
package hnt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W = 4;
    localparam int USED_W = 5;

    localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0] CHAN_HASH_RESET = 8'd8;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic [31:0]       id;
        logic signed [7:0] strength;
        logic [7:0]        hash;
        logic              on_channel;
        logic              text_flag;
        logic [31:0]       stamp;
        logic [31:0]       count;
    } hnt_entry_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        hnt_entry_t        wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } hnt_ram_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] entry_slot;
        logic              was_new;
        logic              did_evict;
        logic [31:0]       evicted_id;
        logic [31:0]       hear_total;
        logic              channel_match;
        logic              text_seen;
        logic [USED_W-1:0] used_entries;
    } hnt_result_t;

endpackage

// File: hw/rtl/hnt_pkt_if.sv
// hnt_pkt_if: input channel carrying one heard packet or clear item
// no dependencies
interface hnt_pkt_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [31:0]       node_id;
    logic [7:0]        chan_hash;
    logic signed [7:0] signal_strength;
    logic              text_decoded;
    logic [31:0]       now_ms;

    modport source (
        output valid, mode, node_id, chan_hash, signal_strength, text_decoded, now_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, node_id, chan_hash, signal_strength, text_decoded, now_ms,
        output ready
    );
endinterface

// File: hw/rtl/hnt_res_if.sv
// hnt_res_if: result channel, one item per accepted input item
// depends on hnt_pkg for field widths
interface hnt_res_if
    import hnt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] entry_slot;
    logic              was_new;
    logic              did_evict;
    logic [31:0]       evicted_id;
    logic [31:0]       hear_total;
    logic              channel_match;
    logic              text_seen;
    logic [USED_W-1:0] used_entries;

    modport source (
        output valid, entry_slot, was_new, did_evict, evicted_id, hear_total,
               channel_match, text_seen, used_entries,
        input  ready
    );
    modport sink (
        input  valid, entry_slot, was_new, did_evict, evicted_id, hear_total,
               channel_match, text_seen, used_entries,
        output ready
    );
endinterface

// File: hw/rtl/hnt_ram.sv
// hnt_ram: generic single write, single read port ram, registered read data
// no dependencies
module hnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/hnt_ctrl.sv
// hnt_ctrl: sequencer that scans the table ram, picks the entry and writes it;
// a clear item empties the table instead; depends on hnt_pkg, hnt_pkt_if and hnt_res_if
module hnt_ctrl
    import hnt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hnt_pkt_if.sink      pkt,
    hnt_res_if.source    res,
    input  logic [7:0]   our_channel_hash,
    output hnt_ram_req_t ram_req,
    input  hnt_entry_t   ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;
    logic [CNT_W-1:0]  issue_idx_reg;
    logic              rvalid_reg;
    logic [IDX_W-1:0]  ridx_reg;

    logic [31:0]       item_id_reg;
    logic [7:0]        item_hash_reg;
    logic signed [7:0] item_strength_reg;
    logic              item_text_reg;
    logic [31:0]       item_now_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  found_slot_reg;
    logic [31:0]       found_count_reg;
    logic              found_text_reg;
    logic [31:0]       oldest_stamp_reg;
    logic [IDX_W-1:0]  oldest_slot_reg;
    logic [31:0]       oldest_id_reg;

    hnt_result_t       result_reg;
    hnt_result_t       out_reg;
    logic              out_valid_reg;

    logic              accept;
    logic              rd_en;
    logic [IDX_W-1:0]  sel_slot;
    logic [31:0]       base_count;
    logic              base_text;
    logic              evict;
    hnt_entry_t        wentry;

    assign pkt.ready = (state_reg == S_IDLE);
    assign accept    = pkt.valid && pkt.ready;
    assign rd_en     = (state_reg == S_SCAN) && (issue_idx_reg < used_reg);

    always_comb
    begin
        sel_slot   = found_slot_reg;
        base_count = found_count_reg;
        base_text  = found_text_reg;
        evict      = 1'b0;
        used_next  = used_reg;
        if (!found_reg)
        begin
            base_count = '0;
            base_text  = 1'b0;
            if (used_reg < CNT_W'(TABLE_ENTRIES))
            begin
                sel_slot  = used_reg[IDX_W-1:0];
                used_next = used_reg + CNT_W'(1);
            end
            else
            begin
                sel_slot = oldest_slot_reg;
                evict    = 1'b1;
            end
        end
        wentry.id         = item_id_reg;
        wentry.strength   = item_strength_reg;
        wentry.hash       = item_hash_reg;
        wentry.on_channel = (item_hash_reg == our_channel_hash);
        wentry.text_flag  = base_text | item_text_reg;
        wentry.stamp      = item_now_reg;
        wentry.count      = base_count + 32'd1;
    end

    always_comb
    begin
        ram_req.we    = (state_reg == S_WRITE);
        ram_req.waddr = sel_slot;
        ram_req.wdata = wentry;
        ram_req.re    = rd_en;
        ram_req.raddr = issue_idx_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            used_reg          <= '0;
            issue_idx_reg     <= '0;
            rvalid_reg        <= 1'b0;
            ridx_reg          <= '0;
            item_id_reg       <= '0;
            item_hash_reg     <= '0;
            item_strength_reg <= '0;
            item_text_reg     <= 1'b0;
            item_now_reg      <= '0;
            found_reg         <= 1'b0;
            found_slot_reg    <= '0;
            found_count_reg   <= '0;
            found_text_reg    <= 1'b0;
            oldest_stamp_reg  <= STAMP_MAX;
            oldest_slot_reg   <= '0;
            oldest_id_reg     <= '0;
            result_reg        <= '0;
            out_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_id_reg       <= pkt.node_id;
                        item_hash_reg     <= pkt.chan_hash;
                        item_strength_reg <= pkt.signal_strength;
                        item_text_reg     <= pkt.text_decoded;
                        item_now_reg      <= pkt.now_ms;
                        found_reg         <= 1'b0;
                        found_slot_reg    <= '0;
                        found_count_reg   <= '0;
                        found_text_reg    <= 1'b0;
                        oldest_stamp_reg  <= STAMP_MAX;
                        oldest_slot_reg   <= '0;
                        oldest_id_reg     <= '0;
                        issue_idx_reg     <= '0;
                        rvalid_reg        <= 1'b0;
                        if (pkt.mode == MODE_CLEAR)
                        begin
                            used_reg   <= '0;
                            result_reg <= '0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    end
                    rvalid_reg <= rd_en;
                    ridx_reg   <= issue_idx_reg[IDX_W-1:0];
                    if (rvalid_reg)
                    begin
                        if (!found_reg && (ram_rdata.id == item_id_reg))
                        begin
                            found_reg       <= 1'b1;
                            found_slot_reg  <= ridx_reg;
                            found_count_reg <= ram_rdata.count;
                            found_text_reg  <= ram_rdata.text_flag;
                        end
                        if ((ridx_reg == '0) || (ram_rdata.stamp < oldest_stamp_reg))
                        begin
                            oldest_stamp_reg <= ram_rdata.stamp;
                            oldest_slot_reg  <= ridx_reg;
                            oldest_id_reg    <= ram_rdata.id;
                        end
                    end
                    else if (!rd_en)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    used_reg                 <= used_next;
                    result_reg.entry_slot    <= SLOT_W'(sel_slot);
                    result_reg.was_new       <= !found_reg;
                    result_reg.did_evict     <= evict;
                    result_reg.evicted_id    <= evict ? oldest_id_reg : 32'd0;
                    result_reg.hear_total    <= wentry.count;
                    result_reg.channel_match <= wentry.on_channel;
                    result_reg.text_seen     <= wentry.text_flag;
                    result_reg.used_entries  <= USED_W'(used_next);
                    state_reg                <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.entry_slot    = out_reg.entry_slot;
    assign res.was_new       = out_reg.was_new;
    assign res.did_evict     = out_reg.did_evict;
    assign res.evicted_id    = out_reg.evicted_id;
    assign res.hear_total    = out_reg.hear_total;
    assign res.channel_match = out_reg.channel_match;
    assign res.text_seen     = out_reg.text_seen;
    assign res.used_entries  = out_reg.used_entries;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("used count beyond table size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (pkt.mode == MODE_CLEAR)) |=> (used_reg == '0))
        else $error("clear did not empty the table");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.re |-> (CNT_W'(ram_req.raddr) < used_reg))
        else $error("read beyond used entries");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the done step");
`endif

endmodule

// File: hw/rtl/heard_node_table_lru.sv
// Heard node table with least-recently-seen replacement.
// pkt: one item per heard packet (mode 0) or clear command (mode 1),
//   taken when pkt.valid and pkt.ready are both high at a rising edge.
// res: one result item per input item, held until res.ready.
// cfg_we/cfg_data: writes our channel hash, taken at the edge where
//   cfg_we is high; reset value 8.
// Steps: a packet walks the used entries through the table ram one read
//   a cycle, then writes the chosen entry and passes its result to the
//   output register; a clear empties the table and goes straight to the output step.
// Flow: one item at a time; pkt.ready is high only while idle, so the
//   next item can be taken from the same cycle in which res.valid rises. A new item
//   may be taken while the previous result still waits.
// Reset clears the used count and the result register; ram contents need
//   no clearing since entries beyond the used count are never read.
// A stalled receiver holds the result; the next item then stops at its
//   last step until the result register is free.
module heard_node_table_lru
    import hnt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hnt_pkt_if.sink    pkt,
    hnt_res_if.source  res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    logic [7:0]   chan_hash_reg;
    hnt_ram_req_t ram_req;
    hnt_entry_t   ram_rdata;
    logic [$bits(hnt_entry_t)-1:0] rdata_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_hash_reg <= CHAN_HASH_RESET;
        end
        else if (cfg_we)
        begin
            chan_hash_reg <= cfg_data;
        end
    end

    hnt_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .pkt              (pkt),
        .res              (res),
        .our_channel_hash (chan_hash_reg),
        .ram_req          (ram_req),
        .ram_rdata        (ram_rdata)
    );

    hnt_ram #(
        .WIDTH ($bits(hnt_entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata_raw)
    );

    assign ram_rdata = hnt_entry_t'(rdata_raw);

endmodule
